// File: hdl/band_ldl_factor_and_solve_defines.svh
// assertion macros for the band ldl factor and solve block
// used by the top level; expects clk and rst in scope
`ifndef BAND_LDL_FACTOR_AND_SOLVE_DEFINES_SVH
`define BAND_LDL_FACTOR_AND_SOLVE_DEFINES_SVH
`ifndef SYNTHESIS
`define BLD_ASSERT_IMP(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (rst) \
  (a) |-> (b)) else $error("band ldl check failed");
`define BLD_ASSERT_NXT(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (rst) \
  (a) |=> (b)) else $error("band ldl check failed");
`else
`define BLD_ASSERT_IMP(lbl, a, b)
`define BLD_ASSERT_NXT(lbl, a, b)
`endif
`endif

// File: hdl/bld_pkg.sv
// shared types, codes and saturating helpers for the band ldl block
// no dependencies
`default_nettype none
package bld_pkg;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_WRITE_BAND = 2'd0,
    OP_FACTOR     = 2'd1,
    OP_WRITE_VEC  = 2'd2,
    OP_SOLVE      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_ORDER = 2'd0,
    REG_BW    = 2'd1,
    REG_SCALE = 2'd2,
    REG_FLOOR = 2'd3
  } cfg_reg_t;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_ELEM = 1'b1;

  typedef enum logic {
    AOP_MUL = 1'b0,
    AOP_DIV = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic              start;
    arith_op_t         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic signed [31:0] value;
  } arith_rsp_t;

  typedef enum logic [1:0] {
    AR_IDLE,
    AR_MUL,
    AR_DIV,
    AR_FIX
  } ar_state_t;

  typedef enum logic [5:0] {
    S_IDLE, S_FS_ADDR, S_FS_DATA, S_FS_TAU, S_FS_TAUW,
    S_FC_BEGIN, S_FC_DG, S_FT_ADDR, S_FT_L, S_FT_A, S_FT_DIV, S_FT_MUL,
    S_FO_ADDR, S_FO_DATA, S_FO_FIX, S_FL_ADDR, S_FL_DATA, S_FL_DIV,
    S_FU_ADDR, S_FU_CAP, S_FU_MUL, S_FE, S_F_DONE,
    S_SC_ADDR, S_SC_DATA, S_SF_BEGIN, S_SF_AUX, S_SF_ADDR, S_SF_CAP, S_SF_MUL,
    S_SF_DADDR, S_SF_DCAP, S_SF_DIV, S_SB_BEGIN, S_SB_AUX, S_SB_ADDR,
    S_SB_CAP, S_SB_MUL, S_SE_ADDR, S_SE_OUT
  } seq_state_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x > 33'sh0_7fff_ffff) begin
      r = Q_MAX;
    end else if (x < -33'sh0_8000_0000) begin
      r = Q_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    return sat33(d);
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] abs_q(input logic signed [31:0] a);
    logic signed [31:0] r;
    if (a == Q_MIN) begin
      r = Q_MAX;
    end else if (a < 0) begin
      r = -a;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/bld_ram.sv
// generic single port ram with registered read
// no dependencies
`default_nettype none
module bld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: hdl/bld_arith.sv
// shared q-format arithmetic unit: rounded multiply and
// bit-serial restoring divide; uses bld_pkg
`default_nettype none
module bld_arith import bld_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire arith_req_t req,
  output arith_rsp_t      rsp
);
  localparam int DW = 33 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic [DW-1:0] Q_POS_LIM = DW'(64'h7fff_ffff);
  localparam logic [DW-1:0] Q_NEG_LIM = DW'(64'h8000_0000);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  ar_state_t          state, state_next;
  logic signed [63:0] prod, prod_next;
  logic [DW-1:0]      dq, dq_next;
  logic [33:0]        rem, rem_next;
  logic [32:0]        dvs, dvs_next;
  logic               neg, neg_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic               done_next;
  logic signed [31:0] value_next;

  logic signed [32:0] ax, bx;
  logic [32:0]        mag_a, mag_b;
  logic signed [63:0] rounded;
  logic [33:0]        rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= AR_IDLE;
      rsp.done <= 1'b0;
    end else begin
      state    <= state_next;
      rsp.done <= done_next;
    end
    prod      <= prod_next;
    dq        <= dq_next;
    rem       <= rem_next;
    dvs       <= dvs_next;
    neg       <= neg_next;
    cnt       <= cnt_next;
    rsp.value <= value_next;
  end

  always_comb begin
    state_next = state;
    prod_next  = prod;
    dq_next    = dq;
    rem_next   = rem;
    dvs_next   = dvs;
    neg_next   = neg;
    cnt_next   = cnt;
    done_next  = 1'b0;
    value_next = rsp.value;
    ax      = {req.a[31], req.a};
    bx      = {req.b[31], req.b};
    mag_a   = ax[32] ? 33'(-ax) : 33'(ax);
    mag_b   = bx[32] ? 33'(-bx) : 33'(bx);
    rounded = (prod + HALF) >>> FRAC_BITS;
    rem_sh  = {rem[32:0], dq[DW-1]};
    unique case (state)
      AR_IDLE: begin
        if (req.start) begin
          if (req.op == AOP_MUL) begin
            prod_next  = 64'(req.a) * 64'(req.b);
            state_next = AR_MUL;
          end else if (req.b == 32'sd0) begin
            // zero divisor gives the signed limit of the dividend, zero for a zero dividend
            done_next  = 1'b1;
            value_next = (req.a > 0) ? Q_MAX : ((req.a < 0) ? Q_MIN : 32'sd0);
          end else begin
            dq_next    = {mag_a, FRAC_BITS'(0)};
            dvs_next   = mag_b;
            rem_next   = '0;
            neg_next   = req.a[31] ^ req.b[31];
            cnt_next   = '0;
            state_next = AR_DIV;
          end
        end
      end
      AR_MUL: begin
        done_next = 1'b1;
        if (rounded > 64'sh7fff_ffff) begin
          value_next = Q_MAX;
        end else if (rounded < -64'sh8000_0000) begin
          value_next = Q_MIN;
        end else begin
          value_next = rounded[31:0];
        end
        state_next = AR_IDLE;
      end
      AR_DIV: begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem_next = rem_sh - {1'b0, dvs};
          dq_next  = {dq[DW-2:0], 1'b1};
        end else begin
          rem_next = rem_sh;
          dq_next  = {dq[DW-2:0], 1'b0};
        end
        cnt_next = cnt + CW'(1);
        if (cnt == CW'(DW - 1)) begin
          state_next = AR_FIX;
        end
      end
      AR_FIX: begin
        done_next = 1'b1;
        if (neg) begin
          value_next = (dq > Q_NEG_LIM) ? Q_MIN : $signed(32'd0 - dq[31:0]);
        end else begin
          value_next = (dq > Q_POS_LIM) ? Q_MAX : $signed(dq[31:0]);
        end
        state_next = AR_IDLE;
      end
      default: state_next = AR_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/band_ldl_factor_and_solve.sv
// top level: command port, apb registers, sequencer over the band,
// vector and work stores; uses bld_pkg, bld_ram, bld_arith and the defines header
//
// usage
//   a command is taken on a clock edge with start high and busy low.
//   opcode 0 writes band entry A[c+b][c], opcode 2 writes a vector
//   element; both leave busy low and give no result, so loads can run
//   back to back. opcode 1 factors the stored band matrix in place as
//   LDL' with diagonal raising and gives one result (kind 0). opcode 3
//   solves with the loaded vector and gives n results (kind 1), in index
//   order, last set on the final one.
//   factor scans the diagonal, then per column runs the trial pivots,
//   the multipliers and the trailing band update; a raised column swaps
//   the trial pivots for a diagonal raise.
//   the divider in the shared arithmetic unit gives one quotient bit per
//   cycle, 33+FRAC_BITS bits, and the band store is single port.
//   busy stays high while a command runs.
//   each result is on the result ports for one cycle, marked by strobe;
//   the receiver cannot stall. reset clears control state and the
//   perturbed flag; the stores hold nothing until written.
`default_nettype none
`include "band_ldl_factor_and_solve_defines.svh"
module band_ldl_factor_and_solve import bld_pkg::*; #(
  parameter int N_MAX     = 64,
  parameter int BW_MAX    = 7,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [2:0]  band_sel,
  input  wire logic [5:0]  row_index,
  input  wire logic [31:0] value,
  output logic             strobe,
  output logic             kind,
  output logic [5:0]       out_index,
  output logic [31:0]      out_value,
  output logic             last,
  output logic             perturbed,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int IW      = $clog2(N_MAX);
  localparam int NW      = $clog2(N_MAX + 1);
  localparam int BWW     = $clog2(BW_MAX + 1);
  localparam int DEPTH_B = (BW_MAX + 1) * N_MAX;
  localparam int BAW     = $clog2(DEPTH_B);

  // configuration registers
  logic [6:0]  matrix_order;
  logic [2:0]  bandwidth;
  logic [16:0] pivot_scale;
  logic [15:0] positivity_floor;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_order     <= 7'd64;
      bandwidth        <= 3'd2;
      pivot_scale      <= 17'd6554;
      positivity_floor <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(paddr[3:2]))
        REG_ORDER: matrix_order     <= pwdata[6:0];
        REG_BW:    bandwidth        <= pwdata[2:0];
        REG_SCALE: pivot_scale      <= pwdata[16:0];
        REG_FLOOR: positivity_floor <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(paddr[3:2]))
      REG_ORDER: prdata = 32'(matrix_order);
      REG_BW:    prdata = 32'(bandwidth);
      REG_SCALE: prdata = 32'(pivot_scale);
      REG_FLOOR: prdata = 32'(positivity_floor);
      default:   prdata = '0;
    endcase
  end

  function automatic logic [BAW-1:0] baddr(input logic [BWW-1:0] b, input logic [IW-1:0] c);
    return BAW'(int'(b) * N_MAX + int'(c));
  endfunction

  // stores
  logic                b_we, v_we, w_we;
  logic [BAW-1:0]      b_addr;
  logic [IW-1:0]       v_addr, w_addr;
  logic signed [31:0]  b_wd, v_wd, w_wd;
  logic signed [31:0]  brd, vrd, wrd;

  bld_ram #(.WIDTH(32), .DEPTH(DEPTH_B)) u_band (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wd), .rdata(brd));
  bld_ram #(.WIDTH(32), .DEPTH(N_MAX)) u_vec (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wd), .rdata(vrd));
  bld_ram #(.WIDTH(32), .DEPTH(N_MAX)) u_work (
    .clk(clk), .we(w_we), .addr(w_addr), .wdata(w_wd), .rdata(wrd));

  arith_req_t ar_req;
  arith_rsp_t ar_rsp;

  bld_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk(clk), .rst(rst), .req(ar_req), .rsp(ar_rsp));

  // sequencer state
  seq_state_t         state, state_next;
  logic [IW-1:0]      i, i_next;
  logic [BWW-1:0]     j, j_next, p, p_next, q, q_next;
  logic signed [31:0] aux, aux_next, tmp, tmp_next, tl, tl_next, dg, dg_next;
  logic signed [31:0] off, off_next, gam, gam_next, tau, tau_next;
  logic               pdef, pdef_next;
  logic               was_perturbed, was_perturbed_next;
  logic signed [31:0] lv [BW_MAX+1];
  logic signed [31:0] el [BW_MAX+1];
  logic               lv_we, el_we;
  logic [BWW-1:0]     el_idx;

  logic               emit, emit_kind, emit_last, emit_pert;
  logic [5:0]         emit_idx;
  logic [31:0]        emit_val;

  logic [NW-1:0]      n, rest;
  logic [BWW-1:0]     bw_eff, m;
  logic               last_col;
  logic [IW-1:0]      col_j, col_q;
  logic signed [31:0] t_val, big, new_d;
  logic signed [32:0] delta;
  logic               acc;

  always_comb begin
    if (matrix_order == 7'd0) begin
      n = NW'(1);
    end else if (int'(matrix_order) > N_MAX) begin
      n = NW'(N_MAX);
    end else begin
      n = NW'(matrix_order);
    end
    bw_eff   = (int'(bandwidth) > BW_MAX) ? BWW'(BW_MAX) : BWW'(bandwidth);
    rest     = n - NW'(1) - NW'(i);
    m        = (int'(rest) < int'(bw_eff)) ? BWW'(rest) : bw_eff;
    last_col = (NW'(i) == n - NW'(1));
    col_j    = IW'(int'(i) + int'(j) + 1);
    col_q    = IW'(int'(i) + int'(q) + 1);
    t_val    = sat_sub(tmp, ar_rsp.value);
    big      = (off > tau) ? off : tau;
    delta    = {big[31], big} - {dg[31], dg};
    if (delta < $signed({17'd0, positivity_floor})) begin
      delta = $signed({17'd0, positivity_floor});
    end
    new_d    = sat_add(dg, sat33(delta));
  end

  assign busy   = (state != S_IDLE);
  assign acc    = start & ~busy;
  assign el_idx = (state == S_FE) ? j : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      was_perturbed <= 1'b0;
      strobe        <= 1'b0;
    end else begin
      state         <= state_next;
      was_perturbed <= was_perturbed_next;
      strobe        <= emit;
    end
    i    <= i_next;
    j    <= j_next;
    p    <= p_next;
    q    <= q_next;
    aux  <= aux_next;
    tmp  <= tmp_next;
    tl   <= tl_next;
    dg   <= dg_next;
    off  <= off_next;
    gam  <= gam_next;
    tau  <= tau_next;
    pdef <= pdef_next;
    if (lv_we) begin
      lv[j] <= brd;
    end
    if (el_we) begin
      el[j] <= ar_rsp.value;
    end
    kind      <= emit_kind;
    out_index <= emit_idx;
    out_value <= emit_val;
    last      <= emit_last;
    perturbed <= emit_pert;
  end

  always_comb begin
    state_next = state;
    i_next = i; j_next = j; p_next = p; q_next = q;
    aux_next = aux; tmp_next = tmp; tl_next = tl; dg_next = dg;
    off_next = off; gam_next = gam; tau_next = tau; pdef_next = pdef;
    was_perturbed_next = was_perturbed;
    lv_we = 1'b0; el_we = 1'b0;
    b_we = 1'b0; b_addr = '0; b_wd = '0;
    v_we = 1'b0; v_addr = '0; v_wd = '0;
    w_we = 1'b0; w_addr = '0; w_wd = '0;
    ar_req = '0;
    emit = 1'b0; emit_kind = KIND_DONE; emit_idx = '0; emit_val = '0;
    emit_last = 1'b0; emit_pert = was_perturbed;

    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (opcode_t'(opcode))
            OP_WRITE_BAND: begin
              if (int'(band_sel) <= BW_MAX && int'(row_index) < N_MAX) begin
                b_we   = 1'b1;
                b_addr = BAW'(int'(band_sel) * N_MAX + int'(row_index));
                b_wd   = value;
              end
            end
            OP_WRITE_VEC: begin
              if (int'(row_index) < N_MAX) begin
                v_we   = 1'b1;
                v_addr = IW'(row_index);
                v_wd   = value;
              end
            end
            OP_FACTOR: begin
              i_next = '0; gam_next = '0; pdef_next = 1'b1;
              state_next = S_FS_ADDR;
            end
            OP_SOLVE: begin
              i_next = '0;
              state_next = S_SC_ADDR;
            end
            default: ;
          endcase
        end
      end
      // diagonal scan for gamma and the first positivity test
      S_FS_ADDR: begin
        b_addr = baddr('0, i);
        state_next = S_FS_DATA;
      end
      S_FS_DATA: begin
        if (brd <= $signed({16'd0, positivity_floor})) begin
          pdef_next = 1'b0;
        end
        if (abs_q(brd) > gam) begin
          gam_next = abs_q(brd);
        end
        if (last_col) begin
          state_next = S_FS_TAU;
        end else begin
          i_next = i + IW'(1);
          state_next = S_FS_ADDR;
        end
      end
      S_FS_TAU: begin
        ar_req = '{start: 1'b1, op: AOP_MUL, a: gam, b: $signed({15'd0, pivot_scale})};
        state_next = S_FS_TAUW;
      end
      S_FS_TAUW: begin
        if (ar_rsp.done) begin
          tau_next = ar_rsp.value;
          i_next = '0;
          state_next = S_FC_BEGIN;
        end
      end
      S_FC_BEGIN: begin
        b_addr = baddr('0, i);
        state_next = S_FC_DG;
      end
      S_FC_DG: begin
        dg_next = brd; j_next = '0; off_next = '0;
        if (!pdef) begin
          state_next = S_FO_ADDR;
        end else if (m == '0) begin
          state_next = S_FL_ADDR;
        end else begin
          state_next = S_FT_ADDR;
        end
      end
      // trial pivots
      S_FT_ADDR: begin
        b_addr = baddr(j + BWW'(1), i);
        state_next = S_FT_L;
      end
      S_FT_L: begin
        tl_next = brd;
        b_addr = baddr('0, col_j);
        state_next = S_FT_A;
      end
      S_FT_A: begin
        tmp_next = brd;
        ar_req = '{start: 1'b1, op: AOP_DIV, a: tl, b: dg};
        state_next = S_FT_DIV;
      end
      S_FT_DIV: begin
        if (ar_rsp.done) begin
          ar_req = '{start: 1'b1, op: AOP_MUL, a: ar_rsp.value, b: tl};
          state_next = S_FT_MUL;
        end
      end
      S_FT_MUL: begin
        if (ar_rsp.done) begin
          if (t_val <= tau) begin
            pdef_next = 1'b0; j_next = '0;
            state_next = S_FO_ADDR;
          end else if (j == m - BWW'(1)) begin
            j_next = '0;
            state_next = S_FL_ADDR;
          end else begin
            j_next = j + BWW'(1);
            state_next = S_FT_ADDR;
          end
        end
      end
      // diagonal raise from the first failing column on
      S_FO_ADDR: begin
        if (j == m) begin
          state_next = S_FO_FIX;
        end else begin
          b_addr = baddr(j + BWW'(1), i);
          state_next = S_FO_DATA;
        end
      end
      S_FO_DATA: begin
        off_next = sat_add(off, abs_q(brd));
        j_next = j + BWW'(1);
        state_next = S_FO_ADDR;
      end
      S_FO_FIX: begin
        b_we = 1'b1; b_addr = baddr('0, i); b_wd = new_d;
        dg_next = new_d; j_next = '0;
        state_next = S_FL_ADDR;
      end
      // multipliers
      S_FL_ADDR: begin
        if (j == m) begin
          p_next = '0; q_next = '0;
          state_next = S_FU_ADDR;
        end else begin
          b_addr = baddr(j + BWW'(1), i);
          state_next = S_FL_DATA;
        end
      end
      S_FL_DATA: begin
        lv_we = 1'b1;
        ar_req = '{start: 1'b1, op: AOP_DIV, a: brd, b: dg};
        state_next = S_FL_DIV;
      end
      S_FL_DIV: begin
        if (ar_rsp.done) begin
          el_we = 1'b1;
          j_next = j + BWW'(1);
          state_next = S_FL_ADDR;
        end
      end
      // trailing band update
      S_FU_ADDR: begin
        if (p == m) begin
          j_next = '0;
          state_next = S_FE;
        end else begin
          b_addr = baddr(p - q, col_q);
          state_next = S_FU_CAP;
        end
      end
      S_FU_CAP: begin
        tmp_next = brd;
        ar_req = '{start: 1'b1, op: AOP_MUL, a: lv[p], b: el[el_idx]};
        state_next = S_FU_MUL;
      end
      S_FU_MUL: begin
        if (ar_rsp.done) begin
          b_we = 1'b1; b_addr = baddr(p - q, col_q); b_wd = t_val;
          if (q == p) begin
            p_next = p + BWW'(1); q_next = '0;
          end else begin
            q_next = q + BWW'(1);
          end
          state_next = S_FU_ADDR;
        end
      end
      S_FE: begin
        if (j == m) begin
          if (last_col) begin
            state_next = S_F_DONE;
          end else begin
            i_next = i + IW'(1);
            state_next = S_FC_BEGIN;
          end
        end else begin
          b_we = 1'b1; b_addr = baddr(j + BWW'(1), i); b_wd = el[el_idx];
          j_next = j + BWW'(1);
        end
      end
      S_F_DONE: begin
        emit = 1'b1; emit_kind = KIND_DONE; emit_last = 1'b1; emit_pert = ~pdef;
        was_perturbed_next = ~pdef;
        state_next = S_IDLE;
      end
      // solve: copy the vector into the work store
      S_SC_ADDR: begin
        v_addr = i;
        state_next = S_SC_DATA;
      end
      S_SC_DATA: begin
        w_we = 1'b1; w_addr = i; w_wd = vrd;
        if (last_col) begin
          i_next = '0;
          state_next = S_SF_BEGIN;
        end else begin
          i_next = i + IW'(1);
          state_next = S_SC_ADDR;
        end
      end
      // forward and diagonal solve
      S_SF_BEGIN: begin
        w_addr = i;
        state_next = S_SF_AUX;
      end
      S_SF_AUX: begin
        aux_next = wrd; j_next = '0;
        state_next = S_SF_ADDR;
      end
      S_SF_ADDR: begin
        if (j == m) begin
          state_next = S_SF_DADDR;
        end else begin
          b_addr = baddr(j + BWW'(1), i);
          w_addr = col_j;
          state_next = S_SF_CAP;
        end
      end
      S_SF_CAP: begin
        tmp_next = wrd;
        ar_req = '{start: 1'b1, op: AOP_MUL, a: brd, b: aux};
        state_next = S_SF_MUL;
      end
      S_SF_MUL: begin
        if (ar_rsp.done) begin
          w_we = 1'b1; w_addr = col_j; w_wd = t_val;
          j_next = j + BWW'(1);
          state_next = S_SF_ADDR;
        end
      end
      S_SF_DADDR: begin
        b_addr = baddr('0, i);
        state_next = S_SF_DCAP;
      end
      S_SF_DCAP: begin
        ar_req = '{start: 1'b1, op: AOP_DIV, a: aux, b: brd};
        state_next = S_SF_DIV;
      end
      S_SF_DIV: begin
        if (ar_rsp.done) begin
          w_we = 1'b1; w_addr = i; w_wd = ar_rsp.value;
          if (last_col) begin
            state_next = S_SB_BEGIN;
          end else begin
            i_next = i + IW'(1);
            state_next = S_SF_BEGIN;
          end
        end
      end
      // backward solve, last row first
      S_SB_BEGIN: begin
        w_addr = i;
        state_next = S_SB_AUX;
      end
      S_SB_AUX: begin
        aux_next = wrd; j_next = '0;
        state_next = S_SB_ADDR;
      end
      S_SB_ADDR: begin
        if (j == m) begin
          w_we = 1'b1; w_addr = i; w_wd = aux;
          if (i == '0) begin
            state_next = S_SE_ADDR;
          end else begin
            i_next = i - IW'(1);
            state_next = S_SB_BEGIN;
          end
        end else begin
          b_addr = baddr(j + BWW'(1), i);
          w_addr = col_j;
          state_next = S_SB_CAP;
        end
      end
      S_SB_CAP: begin
        ar_req = '{start: 1'b1, op: AOP_MUL, a: brd, b: wrd};
        state_next = S_SB_MUL;
      end
      S_SB_MUL: begin
        if (ar_rsp.done) begin
          aux_next = sat_sub(aux, ar_rsp.value);
          j_next = j + BWW'(1);
          state_next = S_SB_ADDR;
        end
      end
      // results out
      S_SE_ADDR: begin
        w_addr = i;
        state_next = S_SE_OUT;
      end
      S_SE_OUT: begin
        emit = 1'b1; emit_kind = KIND_ELEM; emit_idx = 6'(i); emit_val = wrd;
        emit_last = last_col;
        if (last_col) begin
          state_next = S_IDLE;
        end else begin
          i_next = i + IW'(1);
          state_next = S_SE_ADDR;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `BLD_ASSERT_NXT(a_last_ends_run, strobe && last, !strobe)
  `BLD_ASSERT_IMP(a_strobe_source, strobe, $past(state) == S_F_DONE || $past(state) == S_SE_OUT)
  `BLD_ASSERT_IMP(a_band_addr_range, b_we, 32'(b_addr) < DEPTH_B)

endmodule
`default_nettype wire
